// File: design/tcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

  // command codes on the input channel
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  // operations handed from the front to the back
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_FILL  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b1;

  localparam logic [7:0] LINE_COLUMNS_RESET = 8'd80;
  localparam logic [6:0] ROW_COUNT_RESET    = 7'd25;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] col;
    logic [5:0] row_index;
    logic [7:0] rect_width;
    logic [6:0] rect_height;
    logic [7:0] glyph;
    logic       glyph_enable;
    logic [3:0] fg_color;
    logic       fg_enable;
    logic [3:0] bg_color;
    logic       bg_enable;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rd_glyph;
    logic [3:0] rd_fg;
    logic [3:0] rd_bg;
    logic       range_error;
  } out_item_t;

  // classified command waiting for the back end
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] col;
    logic [5:0] row_index;
    logic [7:0] cols_n;
    logic [6:0] rows_n;
    logic [7:0] glyph;
    logic       glyph_enable;
    logic [3:0] fg_color;
    logic       fg_enable;
    logic [3:0] bg_color;
    logic       bg_enable;
    logic       err;
  } entry_t;

endpackage

`default_nettype wire

// File: design/tcf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcf_front #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned NC_W        = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [tcf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire tcf_pkg::in_item_t             in_item_i,
  input  wire logic                          hold_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output tcf_pkg::entry_t                    q_entry_o,
  output logic [NC_W-1:0]                    stride_o
);
  import tcf_pkg::*;

  localparam int unsigned NR_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned EXT_W = 9;

  logic [7:0] line_cols_q;
  logic [6:0] row_cnt_q;

  logic [NC_W-1:0]  nc;
  logic [NR_W-1:0]  nr;
  logic [EXT_W-1:0] nc_x, nr_x;
  logic [EXT_W-1:0] end_c, end_r, lim_c, lim_r;
  logic             cell_ok, fill_err;
  logic [7:0]       cols_n;
  logic [6:0]       rows_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cols_q <= LINE_COLUMNS_RESET;
      row_cnt_q   <= ROW_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LINE_COLUMNS: line_cols_q <= cfg_wdata_i[7:0];
        CFG_ROW_COUNT:    row_cnt_q   <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // configured size clamped to capacity
  assign nc   = (line_cols_q > MAX_COLUMNS) ? NC_W'(MAX_COLUMNS) : NC_W'(line_cols_q);
  assign nr   = (row_cnt_q > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(row_cnt_q);
  assign nc_x = EXT_W'(nc);
  assign nr_x = EXT_W'(nr);

  assign cell_ok = (EXT_W'(in_item_i.col) < nc_x) && (EXT_W'(in_item_i.row_index) < nr_x);

  // clip the rectangle at the far edges; the near corner is either inside or all is out
  assign end_c = EXT_W'(in_item_i.col) + EXT_W'(in_item_i.rect_width);
  assign end_r = EXT_W'(in_item_i.row_index) + EXT_W'(in_item_i.rect_height);
  assign lim_c = (end_c > nc_x) ? nc_x : end_c;
  assign lim_r = (end_r > nr_x) ? nr_x : end_r;
  assign cols_n = cell_ok ? 8'(lim_c - EXT_W'(in_item_i.col)) : 8'd0;
  assign rows_n = cell_ok ? 7'(lim_r - EXT_W'(in_item_i.row_index)) : 7'd0;
  assign fill_err = (in_item_i.rect_width != 8'd0) && (in_item_i.rect_height != 7'd0)
                    && ((end_c > nc_x) || (end_r > nr_x));

  always_comb begin
    q_entry_o              = '0;
    q_entry_o.col          = in_item_i.col;
    q_entry_o.row_index    = in_item_i.row_index;
    q_entry_o.cols_n       = cols_n;
    q_entry_o.rows_n       = rows_n;
    q_entry_o.glyph        = in_item_i.glyph;
    q_entry_o.glyph_enable = in_item_i.glyph_enable;
    q_entry_o.fg_color     = in_item_i.fg_color;
    q_entry_o.fg_enable    = in_item_i.fg_enable;
    q_entry_o.bg_color     = in_item_i.bg_color;
    q_entry_o.bg_enable    = in_item_i.bg_enable;
    q_entry_o.op           = OP_NOP;
    q_entry_o.err          = 1'b0;
    case (in_item_i.cmd)
      CMD_READ: begin
        q_entry_o.op  = cell_ok ? OP_READ : OP_NOP;
        q_entry_o.err = !cell_ok;
      end
      CMD_WRITE: begin
        q_entry_o.op  = cell_ok ? OP_WRITE : OP_NOP;
        q_entry_o.err = !cell_ok;
      end
      CMD_FILL: begin
        q_entry_o.op  = (cols_n != 8'd0 && rows_n != 7'd0) ? OP_FILL : OP_NOP;
        q_entry_o.err = fill_err;
      end
      default: ;
    endcase
  end

  assign in_ready_o = !q_full_i && !hold_i;
  assign q_push_o   = in_valid_i && in_ready_o;
  assign stride_o   = nc;

endmodule

`default_nettype wire

// File: design/tcf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tcf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tcf_pkg::entry_t push_entry_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output tcf_pkg::entry_t      head_o
);
  import tcf_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = 1;
  localparam int unsigned CNT_W = 2;

  entry_t           slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count slip");

endmodule

`default_nettype wire

// File: design/tcf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcf_back #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned COLOR_BITS  = 4,
  parameter int unsigned NC_W        = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire tcf_pkg::entry_t q_head_i,
  output logic                 q_pop_o,
  input  wire logic [NC_W-1:0] stride_i,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output tcf_pkg::out_item_t   out_item_o
);
  import tcf_pkg::*;

  localparam int unsigned DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PROD_W = 6 + NC_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;

  logic [7:0]            glyph_mem [DEPTH];
  logic [COLOR_BITS-1:0] fg_mem    [DEPTH];
  logic [COLOR_BITS-1:0] bg_mem    [DEPTH];

  logic [1:0]            state_q, state_d;
  logic [ADDR_W-1:0]     clr_q;
  logic [ADDR_W-1:0]     f_addr_q, f_base_q;
  logic [7:0]            f_col_q;
  logic [6:0]            f_row_q;
  entry_t                fill_q;

  logic                  out_valid_q, out_rd_q, out_err_q;
  logic [7:0]            rd_glyph_q;
  logic [COLOR_BITS-1:0] rd_fg_q, rd_bg_q;

  logic [PROD_W-1:0]     prod;
  logic [ADDR_W-1:0]     head_addr;
  logic                  out_free, out_load, fill_done;

  logic                  mem_we, we_glyph, we_fg, we_bg;
  logic [ADDR_W-1:0]     mem_addr;
  logic [7:0]            wd_glyph;
  logic [COLOR_BITS-1:0] wd_fg, wd_bg;

  assign prod      = PROD_W'(q_head_i.row_index) * PROD_W'(stride_i);
  assign head_addr = ADDR_W'(prod) + ADDR_W'(q_head_i.col);

  assign out_free   = !out_valid_q || out_ready_i;
  assign q_pop_o    = (state_q == ST_RUN) && q_valid_i && out_free;
  assign out_load   = q_pop_o && (q_head_i.op != OP_FILL);
  assign fill_done  = (state_q == ST_FILL) && (f_col_q == 8'd1) && (f_row_q == 7'd1);
  assign clearing_o = (state_q == ST_CLEAR);

  // one write port shared by the clearing pass, single writes and fills
  always_comb begin
    mem_we   = 1'b0;
    we_glyph = 1'b0;
    we_fg    = 1'b0;
    we_bg    = 1'b0;
    mem_addr = head_addr;
    wd_glyph = q_head_i.glyph;
    wd_fg    = (COLOR_BITS)'(q_head_i.fg_color);
    wd_bg    = (COLOR_BITS)'(q_head_i.bg_color);
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        we_glyph = 1'b1;
        we_fg    = 1'b1;
        we_bg    = 1'b1;
        mem_addr = clr_q;
        wd_glyph = '0;
        wd_fg    = '0;
        wd_bg    = '0;
      end
      ST_RUN: begin
        mem_we   = q_pop_o && (q_head_i.op == OP_WRITE);
        we_glyph = q_head_i.glyph_enable;
        we_fg    = q_head_i.fg_enable;
        we_bg    = q_head_i.bg_enable;
      end
      ST_FILL: begin
        mem_we   = 1'b1;
        we_glyph = fill_q.glyph_enable;
        we_fg    = fill_q.fg_enable;
        we_bg    = fill_q.bg_enable;
        mem_addr = f_addr_q;
        wd_glyph = fill_q.glyph;
        wd_fg    = (COLOR_BITS)'(fill_q.fg_color);
        wd_bg    = (COLOR_BITS)'(fill_q.bg_color);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && we_glyph) glyph_mem[mem_addr] <= wd_glyph;
    if (mem_we && we_fg) fg_mem[mem_addr] <= wd_fg;
    if (mem_we && we_bg) bg_mem[mem_addr] <= wd_bg;
  end

  // read data holds until the next read, which waits for the result to be taken
  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_head_i.op == OP_READ)) begin
      rd_glyph_q <= glyph_mem[head_addr];
      rd_fg_q    <= fg_mem[head_addr];
      rd_bg_q    <= bg_mem[head_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_RUN;
      ST_RUN:   if (q_pop_o && (q_head_i.op == OP_FILL)) state_d = ST_FILL;
      ST_FILL:  if (fill_done) state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_rd_q    <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_rd_q    <= (q_head_i.op == OP_READ);
        out_err_q   <= q_head_i.err;
      end else if (fill_done) begin
        out_valid_q <= 1'b1;
        out_rd_q    <= 1'b0;
        out_err_q   <= fill_q.err;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // fill walks the clipped rectangle row by row
  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_head_i.op == OP_FILL)) begin
      fill_q   <= q_head_i;
      f_addr_q <= head_addr;
      f_base_q <= head_addr;
      f_col_q  <= q_head_i.cols_n;
      f_row_q  <= q_head_i.rows_n;
    end else if (state_q == ST_FILL) begin
      if (f_col_q == 8'd1) begin
        f_base_q <= f_base_q + ADDR_W'(stride_i);
        f_addr_q <= f_base_q + ADDR_W'(stride_i);
        f_col_q  <= fill_q.cols_n;
        f_row_q  <= f_row_q - 7'd1;
      end else begin
        f_addr_q <= f_addr_q + 1'b1;
        f_col_q  <= f_col_q - 8'd1;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_item_o.rd_glyph    = out_rd_q ? rd_glyph_q : 8'd0;
  assign out_item_o.rd_fg       = out_rd_q ? 4'(rd_fg_q) : 4'd0;
  assign out_item_o.rd_bg       = out_rd_q ? 4'(rd_bg_q) : 4'd0;
  assign out_item_o.range_error = out_err_q;

  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !q_pop_o) else $error("command taken during clearing pass");
  a_fill_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> !out_valid_q) else $error("result pending during fill");
  a_fill_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (f_col_q != 8'd0) && (f_row_q != 7'd0))
    else $error("fill counter ran out");
  a_fill_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |=> out_valid_q && !out_rd_q) else $error("fill result missing");

endmodule

`default_nettype wire

// File: design/text_cell_framebuffer_fill_unit.sv
// Character-cell frame store with read, masked write and rectangle fill.
// Input channel in_valid_i/in_ready_o carries one command item; every item
// gives exactly one result item on out_valid_o/out_ready_i, in order.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 columns per row, 1 row count); write only while the block is idle.
// Cell address is col + row * columns; cells outside the configured area
// are skipped and flagged with range_error.
// A read or write result passes through the queue and the output register;
// reads and writes sustain one item per cycle, set by the single memory port,
// while results are taken. A fill holds the back end for one memory write
// per cell of the clipped width times height; later items queue behind it.
// After reset the store is cleared one cell per cycle, MAX_COLUMNS * MAX_ROWS
// cells (8192 by default), with in_ready_o low; config writes still land.
// When the receiver stalls the result holds in the output register, a two
// entry queue keeps accepting until full, then in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_framebuffer_fill_unit #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned COLOR_BITS  = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [tcf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire tcf_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output tcf_pkg::out_item_t                  out_item_o
);
  import tcf_pkg::*;

  localparam int unsigned NC_W = $clog2(MAX_COLUMNS + 1);

  logic            q_push, q_full, q_valid, q_pop, clearing;
  entry_t          push_entry, head_entry;
  logic [NC_W-1:0] stride;

  tcf_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .NC_W       (NC_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .hold_i     (clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry),
    .stride_o   (stride)
  );

  tcf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .head_o      (head_entry)
  );

  tcf_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .COLOR_BITS (COLOR_BITS),
    .NC_W       (NC_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (head_entry),
    .q_pop_o    (q_pop),
    .stride_i   (stride),
    .clearing_o (clearing),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tcf_pkg::*;

  localparam int unsigned MAX_COLS    = 128;
  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;

  text_cell_framebuffer_fill_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the frame store and geometry registers
  logic [7:0] glyph_m [STORE_DEPTH];
  logic [3:0] fg_m    [STORE_DEPTH];
  logic [3:0] bg_m    [STORE_DEPTH];
  logic [7:0] line_cols_m = LINE_COLUMNS_RESET;
  logic [6:0] rows_m      = ROW_COUNT_RESET;

  out_item_t   cell_results_q [$];
  out_item_t   want_res;
  int unsigned err_cnt   = 0;
  int unsigned sent_cnt  = 0;
  bit          no_idle   = 1'b0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  function automatic int unsigned eff_cols();
    int unsigned v;
    v = line_cols_m;
    return (v > MAX_COLS) ? MAX_COLS : v;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned v;
    v = rows_m;
    return (v > MAX_ROWS) ? MAX_ROWS : v;
  endfunction

  function automatic void store_cell(input int unsigned addr, input in_item_t it);
    if (it.glyph_enable) glyph_m[addr] = it.glyph;
    if (it.fg_enable) fg_m[addr] = it.fg_color;
    if (it.bg_enable) bg_m[addr] = it.bg_color;
  endfunction

  // applies one command to the shadow store and returns the cell result
  function automatic out_item_t apply_cmd(input in_item_t it);
    out_item_t   res;
    int unsigned nc, nr, c, r, c_end, r_end, addr;
    res = '0;
    nc = eff_cols();
    nr = eff_rows();
    addr = it.col + it.row_index * nc;
    case (it.cmd)
      CMD_READ: begin
        if (it.col < nc && it.row_index < nr) begin
          res.rd_glyph = glyph_m[addr];
          res.rd_fg    = fg_m[addr];
          res.rd_bg    = bg_m[addr];
        end else begin
          res.range_error = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (it.col < nc && it.row_index < nr) store_cell(addr, it);
        else res.range_error = 1'b1;
      end
      CMD_FILL: begin
        // an empty rectangle touches nothing and is never an error
        if (it.rect_width != 0 && it.rect_height != 0) begin
          c_end = it.col + it.rect_width;
          r_end = it.row_index + it.rect_height;
          if (c_end > nc || r_end > nr) res.range_error = 1'b1;
          for (c = it.col; c < c_end && c < nc; c++) begin
            for (r = it.row_index; r < r_end && r < nr; r++) store_cell(c + r * nc, it);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cell_results_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none pending expected none actual %0h",
                 $time, out_item_o);
      end else begin
        want_res = cell_results_q.pop_front();
        check_field("rd_glyph", want_res.rd_glyph, out_item_o.rd_glyph);
        check_field("rd_fg", 8'(want_res.rd_fg), 8'(out_item_o.rd_fg));
        check_field("rd_bg", 8'(want_res.rd_bg), 8'(out_item_o.rd_bg));
        check_field("range_error", 8'(want_res.range_error), 8'(out_item_o.range_error));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 9);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  // with valid still high; the caller sends again or lowers valid
  task automatic send_item(input in_item_t it);
    if (!no_idle && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cell_results_q.push_back(apply_cmd(it));
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (cell_results_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LINE_COLUMNS) line_cols_m = val;
    else rows_m = val[6:0];
  endtask

  task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
    write_cfg(CFG_LINE_COLUMNS, cols);
    write_cfg(CFG_ROW_COUNT, rows);
  endtask

  function automatic in_item_t rand_fields(input logic [1:0] cmd);
    in_item_t it;
    it.cmd         = cmd;
    it.col         = 7'($urandom);
    it.row_index   = 6'($urandom);
    it.rect_width  = 8'($urandom_range(0, 8));
    it.rect_height = 7'($urandom_range(0, 4));
    it.glyph       = 8'($urandom);
    it.fg_color    = 4'($urandom);
    it.bg_color    = 4'($urandom);
    if ($urandom_range(0, 3) == 0)
      {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'($urandom);
    else
      {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'b111;
    return it;
  endfunction

  function automatic in_item_t mk(input logic [1:0] cmd, input int unsigned c,
                                  input int unsigned r, input int unsigned w,
                                  input int unsigned h);
    in_item_t it;
    it = rand_fields(cmd);
    it.col         = 7'(c);
    it.row_index   = 6'(r);
    it.rect_width  = 8'(w);
    it.rect_height = 7'(h);
    return it;
  endfunction

  // mostly inside the configured area, sometimes anywhere
  function automatic int unsigned pick(input int unsigned lim, input int unsigned full);
    if (lim == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, full);
    return $urandom_range(0, lim - 1);
  endfunction

  task automatic test_directed();
    in_item_t it;
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    it = mk(CMD_WRITE, 0, 0, 0, 0);
    it.glyph = 8'hFF; it.fg_color = 4'hF; it.bg_color = 4'hF;
    {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'b111;
    send_item(it);
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    // masked writes keep the disabled fields
    it.glyph = 8'h00; {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'b100;
    send_item(it);
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    it.fg_color = 4'h0; {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'b010;
    send_item(it);
    it.glyph = 8'hAA; it.bg_color = 4'h0;
    {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'b001;
    send_item(it);
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    it = mk(CMD_WRITE, 79, 24, 0, 0);
    {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'b111;
    send_item(it);
    send_item(mk(CMD_READ, 79, 24, 0, 0));
    // just outside and far outside the default area
    send_item(mk(CMD_WRITE, 80, 0, 0, 0));
    send_item(mk(CMD_WRITE, 127, 63, 0, 0));
    send_item(mk(CMD_READ, 0, 25, 0, 0));
    send_item(mk(CMD_READ, 127, 63, 0, 0));
    send_item(mk(CMD_FILL, 5, 5, 0, 63));
    send_item(mk(CMD_FILL, 5, 5, 255, 0));
    send_item(mk(CMD_FILL, 78, 23, 5, 5));
    send_item(mk(CMD_READ, 79, 24, 0, 0));
    send_item(mk(CMD_FILL, 10, 2, 3, 2));
    send_item(mk(CMD_READ, 12, 3, 0, 0));
    it = mk(CMD_FILL, 10, 2, 3, 2);
    {it.glyph_enable, it.fg_enable, it.bg_enable} = 3'b000;
    send_item(it);
    it = rand_fields(CMD_UNUSED);
    it.rect_width = 8'($urandom);
    send_item(it);
    send_item(mk(CMD_READ, 11, 2, 0, 0));
    settle();
  endtask

  task automatic test_geometry_extremes();
    // oversized registers act as the store capacity
    set_geometry(8'd255, 8'd255);
    send_item(mk(CMD_WRITE, 127, 63, 0, 0));
    send_item(mk(CMD_READ, 127, 63, 0, 0));
    send_item(mk(CMD_READ, 0, 1, 0, 0));
    send_item(mk(CMD_FILL, 0, 0, 255, 127));
    send_item(mk(CMD_READ, 64, 32, 0, 0));
    set_geometry(8'd128, 8'd64);
    send_item(mk(CMD_FILL, 0, 0, 128, 64));
    send_item(mk(CMD_READ, 127, 63, 0, 0));
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    // no valid cell at all
    set_geometry(8'd0, 8'd0);
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    send_item(mk(CMD_WRITE, 0, 0, 0, 0));
    send_item(mk(CMD_FILL, 0, 0, 1, 1));
    send_item(mk(CMD_FILL, 0, 0, 0, 1));
    set_geometry(8'd1, 8'd1);
    send_item(mk(CMD_WRITE, 0, 0, 0, 0));
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    send_item(mk(CMD_READ, 1, 0, 0, 0));
    send_item(mk(CMD_READ, 0, 1, 0, 0));
    send_item(mk(CMD_FILL, 0, 0, 2, 1));
    set_geometry(8'd0, 8'd64);
    send_item(mk(CMD_READ, 3, 3, 0, 0));
    set_geometry(8'd128, 8'd0);
    send_item(mk(CMD_READ, 3, 3, 0, 0));
    // row register only keeps seven bits
    set_geometry(8'd130, 8'h81);
    send_item(mk(CMD_WRITE, 100, 0, 0, 0));
    send_item(mk(CMD_READ, 100, 0, 0, 0));
    send_item(mk(CMD_READ, 100, 1, 0, 0));
    settle();
  endtask

  task automatic run_traffic(input int unsigned n, input bit pause_mid);
    int unsigned stop_at, kind, c, r, len, k;
    in_item_t    it;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      c = pick(eff_cols(), 127);
      r = pick(eff_rows(), 63);
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // text string: single-cell writes at successive columns
        len = $urandom_range(1, 12);
        for (k = 0; k < len && c + k < MAX_COLS; k++) send_item(mk(CMD_WRITE, c + k, r, 0, 0));
      end else if (kind < 55) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len && c + k < MAX_COLS; k++) send_item(mk(CMD_READ, c + k, r, 0, 0));
      end else if (kind < 75) begin
        it = mk(CMD_FILL, c, r, $urandom_range(0, 8), $urandom_range(0, 4));
        send_item(it);
        send_item(mk(CMD_READ, c, r, 0, 0));
        if (it.rect_width != 0 && it.rect_height != 0 && c + it.rect_width <= MAX_COLS &&
            r + it.rect_height <= MAX_ROWS)
          send_item(mk(CMD_READ, c + it.rect_width - 1, r + it.rect_height - 1, 0, 0));
      end else if (kind < 82) begin
        // one dimension huge, the other tiny, to keep fills short
        if ($urandom_range(0, 1) == 1)
          it = mk(CMD_FILL, c, r, 8'($urandom), $urandom_range(0, 2));
        else
          it = mk(CMD_FILL, c, r, $urandom_range(0, 2), 7'($urandom));
        send_item(it);
      end else begin
        it = rand_fields(2'($urandom));
        it.rect_width = 8'($urandom);
        send_item(it);
      end
      if (pause_mid && sent_cnt + n / 2 >= stop_at) begin
        pause_mid = 1'b0;
        settle();
      end
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned ph;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_geometry(LINE_COLUMNS_RESET, 8'(ROW_COUNT_RESET));
        1: set_geometry(8'd128, 8'd64);
        2: set_geometry(8'($urandom_range(1, 128)), 8'($urandom_range(1, 64)));
        3: set_geometry(8'($urandom), 8'($urandom));
        default: set_geometry(8'd40, 8'd50);
      endcase
      run_traffic(320, ph == 2);
    end
  endtask

  task automatic test_burst_no_idle();
    set_geometry(8'd64, 8'd32);
    no_idle = 1'b1;
    run_traffic(200, 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    // receiver stops for a long stretch while items keep coming
    hold_req++;
    run_traffic(60, 1'b0);
  endtask

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    int unsigned i;
    for (i = 0; i < STORE_DEPTH; i++) begin
      glyph_m[i] = '0;
      fg_m[i]    = '0;
      bg_m[i]    = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_geometry_extremes();
    test_random_traffic();
    test_burst_no_idle();
    test_backpressure();
    settle();
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
